FILE: rtl/core/fccsw_pkg.sv
`default_nettype none
package fccsw_pkg;

   localparam logic [2:0] ACT_OPEN  = 3'd0;
   localparam logic [2:0] ACT_CLOSE = 3'd1;
   localparam logic [2:0] ACT_NEXT  = 3'd2;
   localparam logic [2:0] ACT_SEEK  = 3'd3;
   localparam logic [2:0] ACT_REPLY = 3'd4;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_REQ  = 2'd1;
   localparam logic [1:0] KIND_STAT = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_EOF    = 3'd1;
   localparam logic [2:0] ST_NOPEN  = 3'd2;
   localparam logic [2:0] ST_BUSY   = 3'd3;
   localparam logic [2:0] ST_UNEXP  = 3'd4;

   localparam logic [2:0] REG_FAT_TYPE  = 3'd0;
   localparam logic [2:0] REG_FAT_START = 3'd1;
   localparam logic [2:0] REG_ROOT      = 3'd2;
   localparam logic [2:0] REG_DATA      = 3'd3;
   localparam logic [2:0] REG_SPC       = 3'd4;
   localparam logic [2:0] REG_LIMIT     = 3'd5;

   localparam logic [1:0] FAT12 = 2'd0;
   localparam logic [1:0] FAT16 = 2'd1;

   localparam logic [1:0] WP_IDLE = 2'd0;
   localparam logic [1:0] WP_WORD = 2'd1;
   localparam logic [1:0] WP_HIGH = 2'd2;
   localparam logic [1:0] WP_LOW  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_SEEKC,
      S_OUT0,
      S_OUT1
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_in;
      logic exec;
      logic div_start;
      logic div_step;
      logic seek_finish;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic div_done;
      logic go_div;
      logic go_seekc;
      logic two_out;
   } stat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] sector;
      logic [8:0]  byte_offset;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/fccsw_if.sv
`default_nettype none
interface fccsw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [27:0] open_cluster;
   logic [31:0] sector_index;
   logic [31:0] fat_data;
   logic        read_failed;
   modport source (output valid, action, open_cluster, sector_index, fat_data,
                   read_failed, input ready);
   modport sink (input valid, action, open_cluster, sector_index, fat_data,
                 read_failed, output ready);
endinterface

interface fccsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] sector;
   logic [8:0]  byte_offset;
   logic [2:0]  status;
   logic        last;
   modport source (output valid, kind, sector, byte_offset, status, last,
                   input ready);
   modport sink (input valid, kind, sector, byte_offset, status, last,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fccsw_ctrl.sv
`default_nettype none
module fccsw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic                 rsp_fire,
   input  wire fccsw_pkg::stat_type  stat,
   output fccsw_pkg::cmd_type        cmd,
   output logic                      req_ready,
   output logic                      rsp_valid,
   output logic                      out_sel
);

   fccsw_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fccsw_pkg::S_IDLE:  if (req_fire) state_in = fccsw_pkg::S_EXEC;
         fccsw_pkg::S_EXEC: begin
            if (stat.go_div) state_in = fccsw_pkg::S_DIV;
            else if (stat.go_seekc) state_in = fccsw_pkg::S_SEEKC;
            else state_in = fccsw_pkg::S_OUT0;
         end
         fccsw_pkg::S_DIV:   if (stat.div_done) state_in = fccsw_pkg::S_SEEKC;
         fccsw_pkg::S_SEEKC: state_in = fccsw_pkg::S_OUT0;
         fccsw_pkg::S_OUT0: begin
            if (rsp_fire) state_in = stat.two_out ? fccsw_pkg::S_OUT1 : fccsw_pkg::S_IDLE;
         end
         fccsw_pkg::S_OUT1:  if (rsp_fire) state_in = fccsw_pkg::S_IDLE;
         default: state_in = fccsw_pkg::S_IDLE;
      endcase
   end

   // Outputs. The input beat is captured on every idle cycle, so the capture at
   // the accepting edge holds the accepted beat.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      out_sel = 1'b0;
      unique case (state_ff)
         fccsw_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_in = 1'b1;
         end
         fccsw_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            cmd.div_start = 1'b1;
         end
         fccsw_pkg::S_DIV:   cmd.div_step = 1'b1;
         fccsw_pkg::S_SEEKC: cmd.seek_finish = 1'b1;
         fccsw_pkg::S_OUT0:  rsp_valid = 1'b1;
         fccsw_pkg::S_OUT1: begin
            rsp_valid = 1'b1;
            out_sel = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fccsw_pkg::S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/fccsw_dp.sv
`default_nettype none
module fccsw_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fccsw_pkg::cmd_type  cmd,
   input  wire logic                out_sel,
   input  wire logic                csr_write,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   input  wire logic [2:0]          in_action,
   input  wire logic [27:0]         in_start,
   input  wire logic [31:0]         in_index,
   input  wire logic [31:0]         in_data,
   input  wire logic                in_failed,
   output fccsw_pkg::stat_type      stat,
   output fccsw_pkg::rsp_type       rsp
);

   // Configuration registers.
   logic [1:0]  fat_type_ff;
   logic [31:0] fat_start_ff, root_start_ff, data_start_ff;
   logic [7:0]  spc_ff;
   logic [28:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_type_ff <= fccsw_pkg::FAT16;
         fat_start_ff <= '0;
         root_start_ff <= '0;
         data_start_ff <= '0;
         spc_ff <= 8'd1;
         limit_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            fccsw_pkg::REG_FAT_TYPE:  fat_type_ff <= csr_data[1:0];
            fccsw_pkg::REG_FAT_START: fat_start_ff <= csr_data;
            fccsw_pkg::REG_ROOT:      root_start_ff <= csr_data;
            fccsw_pkg::REG_DATA:      data_start_ff <= csr_data;
            fccsw_pkg::REG_SPC:       spc_ff <= csr_data[7:0];
            fccsw_pkg::REG_LIMIT:     limit_ff <= csr_data[28:0];
            default: ;
         endcase
      end
   end

   // Latched input beat.
   logic [2:0]  act_ff;
   logic [27:0] start_ff;
   logic [31:0] idx_ff, data_ff;
   logic        failed_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         act_ff <= in_action;
         start_ff <= in_start;
         idx_ff <= in_index;
         data_ff <= in_data;
         failed_ff <= in_failed;
      end
   end

   // Walker state.
   logic [27:0] first_ff, first_in, cur_ff, cur_in;
   logic [15:0] sic_ff, sic_in;
   logic [1:0]  wp_ff, wp_in;
   logic        pseek_ff, pseek_in;
   logic [31:0] hops_ff, hops_in;
   logic [7:0]  hib_ff, hib_in;
   fccsw_pkg::rsp_type r0_ff, r0_in, r1_ff, r1_in;
   logic        two_ff, two_in, godiv_in;

   // Divider: quotient into hops, remainder into sector_in_cluster.
   logic [31:0] dq_ff;
   logic [8:0]  drem_ff;
   logic [5:0]  dcnt_ff;
   logic [8:0]  csize;
   logic [9:0]  dtrial;
   assign csize = (spc_ff == 8'd0) ? 9'd256 : {1'b0, spc_ff};
   assign dtrial = {drem_ff, dq_ff[31]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff <= idx_ff;
         drem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != 6'd32) begin
         if (dtrial >= {1'b0, csize}) begin
            drem_ff <= 9'(dtrial - {1'b0, csize});
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            drem_ff <= dtrial[8:0];
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   // Seek finish takes hops from the divider or from the stored count.
   logic        from_div_ff;
   logic [31:0] seek_hops;
   assign seek_hops = from_div_ff ? dq_ff : hops_ff;

   function automatic fccsw_pkg::rsp_type mk(input logic [1:0] k, input logic [31:0] s,
                                            input logic [8:0] o, input logic [2:0] st);
      fccsw_pkg::rsp_type r;
      r.kind = k; r.sector = s; r.byte_offset = o; r.status = st; r.last = 1'b1;
      return r;
   endfunction

   function automatic fccsw_pkg::rsp_type stat_r(input logic [2:0] st);
      return mk(fccsw_pkg::KIND_STAT, 32'd0, 9'd0, st);
   endfunction

   // Shared lookup: request for the link of the current cluster.
   logic        lk_ok;
   logic [1:0]  lk_wp;
   fccsw_pkg::rsp_type lk_r;
   logic [28:0] bc;
   always_comb begin
      lk_ok = (cur_ff >= 28'd2) && ({1'b0, cur_ff} < limit_ff);
      bc = {1'b0, cur_ff} + {2'b0, cur_ff[27:1]};
      lk_wp = fccsw_pkg::WP_WORD;
      if (fat_type_ff == fccsw_pkg::FAT12) begin
         if (bc[8:0] == 9'h1FF) begin
            lk_r = mk(fccsw_pkg::KIND_REQ, fat_start_ff + 32'(bc[28:9]) + 32'd1, 9'd0,
                      fccsw_pkg::ST_OK);
            lk_wp = fccsw_pkg::WP_HIGH;
         end else begin
            lk_r = mk(fccsw_pkg::KIND_REQ, fat_start_ff + 32'(bc[28:9]), bc[8:0],
                      fccsw_pkg::ST_OK);
         end
      end else if (fat_type_ff == fccsw_pkg::FAT16) begin
         lk_r = mk(fccsw_pkg::KIND_REQ, fat_start_ff + 32'(cur_ff[27:8]),
                   {cur_ff[7:0], 1'b0}, fccsw_pkg::ST_OK);
      end else begin
         lk_r = mk(fccsw_pkg::KIND_REQ, fat_start_ff + 32'(cur_ff[27:7]),
                   {cur_ff[6:0], 2'b0}, fccsw_pkg::ST_OK);
      end
   end

   // Address of the current sector: one multiply feeds the next-sector path.
   logic [31:0] mul_addr;
   assign mul_addr = data_start_ff + 32'(32'(cur_ff - 28'd2) * 32'(csize))
                     + 32'(sic_ff);

   // Decoded reply link.
   logic [31:0] v;
   logic [15:0] wc;
   logic        v_ok;
   always_comb begin
      wc = (wp_ff == fccsw_pkg::WP_LOW) ? {hib_ff, data_ff[7:0]} : data_ff[15:0];
      if (wp_ff == fccsw_pkg::WP_LOW || fat_type_ff == fccsw_pkg::FAT12)
         v = cur_ff[0] ? {20'd0, wc[15:4]} : {20'd0, wc[11:0]};
      else if (fat_type_ff == fccsw_pkg::FAT16)
         v = {16'd0, data_ff[15:0]};
      else
         v = {4'd0, data_ff[27:0]};
      v_ok = (v >= 32'd2) && (v < {3'd0, limit_ff});
   end

   logic [16:0] sic_inc;
   logic [32:0] root_pos;
   logic [32:0] seek_root;
   logic [27:0] reply_cur;
   assign sic_inc = {1'b0, sic_ff} + 17'd1;
   assign root_pos = {1'b0, root_start_ff} + 33'(sic_inc);
   assign seek_root = {1'b0, root_start_ff} + {1'b0, idx_ff};

   // Main update.
   always_comb begin
      first_in = first_ff; cur_in = cur_ff; sic_in = sic_ff; wp_in = wp_ff;
      pseek_in = pseek_ff; hops_in = hops_ff; hib_in = hib_ff;
      r0_in = r0_ff; r1_in = r1_ff; two_in = two_ff; godiv_in = 1'b0;
      reply_cur = failed_ff ? 28'd0 : (v_ok ? v[27:0] : 28'd0);
      if (cmd.exec) begin
         two_in = 1'b0;
         r0_in = stat_r(fccsw_pkg::ST_UNEXP);
         unique case (act_ff)
            fccsw_pkg::ACT_OPEN, fccsw_pkg::ACT_CLOSE: begin
               first_in = (act_ff == fccsw_pkg::ACT_OPEN) ? start_ff : 28'd0;
               cur_in = first_in;
               sic_in = '0; wp_in = fccsw_pkg::WP_IDLE; pseek_in = 1'b0;
               hops_in = '0; hib_in = '0;
               r0_in = stat_r(fccsw_pkg::ST_OK);
            end
            fccsw_pkg::ACT_NEXT, fccsw_pkg::ACT_SEEK: begin
               if (wp_ff != fccsw_pkg::WP_IDLE) r0_in = stat_r(fccsw_pkg::ST_BUSY);
               else if (first_ff == 28'd0) r0_in = stat_r(fccsw_pkg::ST_NOPEN);
               else if (act_ff == fccsw_pkg::ACT_NEXT) begin
                  if (cur_ff == 28'd0) r0_in = stat_r(fccsw_pkg::ST_EOF);
                  else if (cur_ff == 28'd1) begin
                     r0_in = mk(fccsw_pkg::KIND_DATA, root_start_ff + 32'(sic_ff), 9'd0,
                                fccsw_pkg::ST_OK);
                     if (sic_ff == 16'hFFFF || root_pos >= {1'b0, data_start_ff}) begin
                        cur_in = '0; sic_in = '0;
                     end else sic_in = sic_inc[15:0];
                  end else begin
                     r0_in = mk(fccsw_pkg::KIND_DATA, mul_addr, 9'd0, fccsw_pkg::ST_OK);
                     if (sic_inc >= 17'(csize)) begin
                        sic_in = '0; pseek_in = 1'b0;
                        if (lk_ok) begin
                           r0_in.last = 1'b0;
                           r1_in = lk_r; two_in = 1'b1; wp_in = lk_wp;
                        end else begin
                           cur_in = '0; wp_in = fccsw_pkg::WP_IDLE;
                        end
                     end else sic_in = sic_inc[15:0];
                  end
               end else if (first_ff == 28'd1) begin
                  if (idx_ff <= 32'hFFFF && seek_root < {1'b0, data_start_ff}) begin
                     cur_in = 28'd1; sic_in = idx_ff[15:0];
                     r0_in = stat_r(fccsw_pkg::ST_OK);
                  end else begin
                     cur_in = '0; sic_in = '0;
                     r0_in = stat_r(fccsw_pkg::ST_EOF);
                  end
               end else begin
                  cur_in = first_ff; pseek_in = 1'b1; godiv_in = 1'b1;
               end
            end
            fccsw_pkg::ACT_REPLY: begin
               if (wp_ff != fccsw_pkg::WP_IDLE) begin
                  if (failed_ff) begin
                     cur_in = '0; wp_in = fccsw_pkg::WP_IDLE;
                  end else if (wp_ff == fccsw_pkg::WP_HIGH) begin
                     hib_in = data_ff[7:0]; wp_in = fccsw_pkg::WP_LOW;
                     r0_in = mk(fccsw_pkg::KIND_REQ, fat_start_ff + 32'(bc[28:9]), 9'h1FF,
                                fccsw_pkg::ST_OK);
                  end else begin
                     cur_in = reply_cur; wp_in = fccsw_pkg::WP_IDLE;
                     if (pseek_ff && hops_ff != 32'd0) hops_in = hops_ff - 32'd1;
                  end
                  if (failed_ff || wp_ff != fccsw_pkg::WP_HIGH) begin
                     r0_in = stat_r((cur_in != 28'd0) ? fccsw_pkg::ST_OK : fccsw_pkg::ST_EOF);
                  end
               end
            end
            default: ;
         endcase
      end
      // Seek continuation: after divide, or after a seek reply.
      if (cmd.seek_finish) begin
         if (seek_hops != 32'd0 && cur_ff != 28'd0 && lk_ok) begin
            r0_in = lk_r; wp_in = lk_wp; hops_in = seek_hops;
            if (from_div_ff) sic_in = 16'(drem_ff);
         end else begin
            hops_in = '0; pseek_in = 1'b0;
            if (from_div_ff) sic_in = 16'(drem_ff);
            if (cur_ff >= 28'd2 && !lk_ok && seek_hops != 32'd0) cur_in = '0;
            r0_in = stat_r(((cur_ff >= 28'd2 && !lk_ok && seek_hops != 32'd0)
                            || cur_ff == 28'd0) ? fccsw_pkg::ST_EOF : fccsw_pkg::ST_OK);
            if (seek_hops != 32'd0 && cur_ff != 28'd0 && !lk_ok) wp_in = fccsw_pkg::WP_IDLE;
         end
      end
   end

   // A completed reply during a seek goes straight to the continuation step.
   logic seek_reply;
   assign seek_reply = cmd.exec && act_ff == fccsw_pkg::ACT_REPLY && pseek_ff &&
                       wp_ff != fccsw_pkg::WP_IDLE &&
                       (failed_ff || wp_ff != fccsw_pkg::WP_HIGH);

   assign stat.div_done = (dcnt_ff == 6'd32);
   assign stat.go_div   = godiv_in;
   assign stat.go_seekc = seek_reply;
   assign stat.two_out  = two_ff;
   assign rsp = out_sel ? r1_ff : r0_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) from_div_ff <= godiv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0; cur_ff <= '0; sic_ff <= '0; wp_ff <= fccsw_pkg::WP_IDLE;
         pseek_ff <= 1'b0; hops_ff <= '0; hib_ff <= '0; two_ff <= 1'b0;
      end else begin
         first_ff <= first_in; cur_ff <= cur_in; sic_ff <= sic_in; wp_ff <= wp_in;
         pseek_ff <= pseek_in; hops_ff <= hops_in; hib_ff <= hib_in; two_ff <= two_in;
      end
      r0_ff <= r0_in;
      r1_ff <= r1_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/fat_cluster_chain_sector_walker_core.sv
// Flow: an input beat is taken in the idle state and then executed; a chain seek also
// runs the serial cluster-size divide and a seek step, and a reply inside a seek runs
// the seek step. A data sector followed by a table request is offered as two results.
// No new input beat is taken until every result of the last one has been taken, so
// result stalls hold back the input.
// Reset: synchronous active-high reset closes the file, idles the walker and loads the configuration defaults.
`default_nettype none
module fat_cluster_chain_sector_walker_core (
   input  wire logic        clock,
   input  wire logic        reset,
   fccsw_req_if.sink        req,
   fccsw_rsp_if.source      rsp,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   // The configuration defaults after reset are a sixteen-bit table and one sector
   // per cluster.
   fccsw_pkg::cmd_type  cmd;
   fccsw_pkg::stat_type stat;
   fccsw_pkg::rsp_type  out;
   logic out_sel, req_fire, rsp_fire;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   fccsw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .stat(stat), .cmd(cmd), .req_ready(req.ready), .rsp_valid(rsp.valid),
      .out_sel(out_sel)
   );

   fccsw_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .out_sel(out_sel),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .in_action(req.action), .in_start(req.open_cluster),
      .in_index(req.sector_index), .in_data(req.fat_data),
      .in_failed(req.read_failed), .stat(stat), .rsp(out)
   );

   assign rsp.kind = out.kind;
   assign rsp.sector = out.sector;
   assign rsp.byte_offset = out.byte_offset;
   assign rsp.status = out.status;
   assign rsp.last = out.last;

   // No input beat is taken while a result is offered.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");

   // A result held back keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.sector) && $stable(rsp.kind))
      else $error("result changed under stall");

endmodule
`default_nettype wire

FILE: test/tb_fat_cluster_chain_sector_walker_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_fat_cluster_chain_sector_walker_core;
   import fccsw_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   fccsw_req_if req ();
   fccsw_rsp_if rsp ();

   fat_cluster_chain_sector_walker_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   localparam int WATCHDOG_LIMIT = 20000;

   // Predictor copy of the configuration registers.
   logic [1:0]  cfg_fat_type;
   logic [31:0] cfg_fat_start, cfg_root_start, cfg_data_start;
   logic [7:0]  cfg_spc;
   logic [28:0] cfg_limit;

   // Predictor copy of the walker state.
   logic [27:0] walk_first;
   logic [31:0] walk_cluster;
   logic [31:0] walk_sector;
   logic [1:0]  walk_phase;
   logic        walk_seek;
   logic [31:0] walk_hops;
   logic [7:0]  walk_high;

   rsp_type     expected_beats[$];
   rsp_type     step_out[$];

   int          error_count;
   int          idle_count;
   int          send_gap_pct;
   int          recv_stall_pct;
   bit          timed_out;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Build one predicted result beat.
   function automatic rsp_type make_beat(logic [1:0] k, logic [31:0] sec,
                                         logic [8:0] ofs, logic [2:0] st);
      rsp_type b;
      b.kind        = k;
      b.sector      = sec;
      b.byte_offset = ofs;
      b.status      = st;
      b.last        = 1'b1;
      return b;
   endfunction

   function automatic logic [31:0] cluster_sectors();
      return (cfg_spc == 8'd0) ? 32'd256 : {24'd0, cfg_spc};
   endfunction

   function automatic bit link_valid(logic [31:0] c);
      return c >= 32'd2 && c < {3'd0, cfg_limit};
   endfunction

   function automatic logic [2:0] chain_status();
      return (walk_cluster != 0) ? ST_OK : ST_EOF;
   endfunction

   // Start a table lookup for the current cluster; returns 1 if a request was issued.
   function automatic bit start_table_lookup();
      logic [31:0] c, bc, sec;
      logic [8:0]  ofs;
      c = walk_cluster;
      if (!link_valid(c)) begin
         walk_cluster = 0;
         walk_phase   = WP_IDLE;
         return 0;
      end
      if (cfg_fat_type == FAT12) begin
         bc  = c + (c >> 1);
         ofs = bc[8:0];
         sec = cfg_fat_start + (bc >> 9);
         if (ofs == 9'd511) begin
            sec        = sec + 1;
            ofs        = 9'd0;
            walk_phase = WP_HIGH;
         end else begin
            walk_phase = WP_WORD;
         end
      end else if (cfg_fat_type == FAT16) begin
         sec        = cfg_fat_start + (c >> 8);
         ofs        = {c[7:0], 1'b0};
         walk_phase = WP_WORD;
      end else begin
         sec        = cfg_fat_start + (c >> 7);
         ofs        = {c[6:0], 2'b00};
         walk_phase = WP_WORD;
      end
      step_out.push_back(make_beat(KIND_REQ, sec, ofs, ST_OK));
      return 1;
   endfunction

   function automatic void seek_step();
      if (walk_hops != 0 && walk_cluster != 0) begin
         if (start_table_lookup()) return;
      end
      walk_hops = 0;
      walk_seek = 1'b0;
      step_out.push_back(make_beat(KIND_STAT, 0, 0, chain_status()));
   endfunction

   // Predict the result beats of one input beat.
   function automatic void predict_walk(logic [2:0] act, logic [27:0] start,
                                        logic [31:0] idx, logic [31:0] data,
                                        logic failed);
      logic [31:0] addr, v, wc, bc, csz;
      rsp_type     b;
      step_out.delete();
      csz = cluster_sectors();
      if (act == ACT_OPEN || act == ACT_CLOSE) begin
         walk_first   = (act == ACT_OPEN) ? start : 28'd0;
         walk_cluster = {4'd0, walk_first};
         walk_sector  = 0;
         walk_phase   = WP_IDLE;
         walk_seek    = 0;
         walk_hops    = 0;
         walk_high    = 0;
         step_out.push_back(make_beat(KIND_STAT, 0, 0, ST_OK));
         return;
      end
      if ((act == ACT_NEXT || act == ACT_SEEK) && walk_phase != WP_IDLE) begin
         step_out.push_back(make_beat(KIND_STAT, 0, 0, ST_BUSY));
         return;
      end
      if ((act == ACT_NEXT || act == ACT_SEEK) && walk_first == 0) begin
         step_out.push_back(make_beat(KIND_STAT, 0, 0, ST_NOPEN));
         return;
      end
      if (act == ACT_NEXT) begin
         if (walk_cluster == 0) begin
            step_out.push_back(make_beat(KIND_STAT, 0, 0, ST_EOF));
            return;
         end
         if (walk_cluster == 1)
            addr = cfg_root_start + walk_sector;
         else
            addr = cfg_data_start + (walk_cluster - 2) * csz + walk_sector;
         step_out.push_back(make_beat(KIND_DATA, addr, 0, ST_OK));
         if (walk_cluster == 1) begin
            if (walk_sector >= 32'hFFFF ||
                {32'd0, cfg_root_start} + walk_sector + 1 >= {32'd0, cfg_data_start}) begin
               walk_cluster = 0;
               walk_sector  = 0;
            end else begin
               walk_sector = walk_sector + 1;
            end
         end else begin
            walk_sector = walk_sector + 1;
            if (walk_sector >= csz) begin
               walk_sector = 0;
               walk_seek   = 0;
               if (start_table_lookup()) begin
                  b = step_out[0];
                  b.last = 1'b0;
                  step_out[0] = b;
               end
            end
         end
         return;
      end
      if (act == ACT_SEEK) begin
         if (walk_first == 1) begin
            if (idx <= 32'hFFFF && {32'd0, cfg_root_start} + idx < {32'd0, cfg_data_start}) begin
               walk_cluster = 1;
               walk_sector  = idx;
            end else begin
               walk_cluster = 0;
               walk_sector  = 0;
            end
            step_out.push_back(make_beat(KIND_STAT, 0, 0, chain_status()));
            return;
         end
         walk_cluster = {4'd0, walk_first};
         walk_sector  = idx % csz;
         walk_hops    = idx / csz;
         walk_seek    = 1;
         seek_step();
         return;
      end
      if (act == ACT_REPLY && walk_phase != WP_IDLE) begin
         if (failed) begin
            walk_cluster = 0;
            walk_phase   = WP_IDLE;
         end else if (walk_phase == WP_HIGH) begin
            bc         = walk_cluster + (walk_cluster >> 1);
            walk_high  = data[7:0];
            walk_phase = WP_LOW;
            step_out.push_back(make_beat(KIND_REQ, cfg_fat_start + (bc >> 9), 9'd511,
                                         ST_OK));
            return;
         end else begin
            if (walk_phase == WP_LOW) begin
               wc = {16'd0, walk_high, data[7:0]};
               v  = walk_cluster[0] ? (wc >> 4) : (wc & 32'hFFF);
            end else if (cfg_fat_type == FAT12) begin
               wc = data & 32'hFFFF;
               v  = walk_cluster[0] ? (wc >> 4) : (wc & 32'hFFF);
            end else if (cfg_fat_type == FAT16) begin
               v = data & 32'hFFFF;
            end else begin
               v = data & 32'h0FFF_FFFF;
            end
            walk_cluster = link_valid(v) ? v : 0;
            walk_phase   = WP_IDLE;
            if (walk_seek && walk_hops != 0) walk_hops = walk_hops - 1;
         end
         if (walk_seek) begin
            seek_step();
            return;
         end
         step_out.push_back(make_beat(KIND_STAT, 0, 0, chain_status()));
         return;
      end
      step_out.push_back(make_beat(KIND_STAT, 0, 0, ST_UNEXP));
   endfunction

   // Send one input beat and queue its predicted results. The valid line stays
   // high after the beat so that a following beat can go out back to back.
   task automatic send_beat(logic [2:0] act, logic [27:0] start, logic [31:0] idx,
                            logic [31:0] data, logic failed);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.action        <= act;
      req.open_cluster  <= start;
      req.sector_index  <= idx;
      req.fat_data      <= data;
      req.read_failed   <= failed;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_walk(act, start, idx, data, failed);
      foreach (step_out[i]) expected_beats.push_back(step_out[i]);
   endtask

   // Write one register while the walker is idle.
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      case (index)
         REG_FAT_TYPE:  cfg_fat_type   = value[1:0];
         REG_FAT_START: cfg_fat_start  = value;
         REG_ROOT:      cfg_root_start = value;
         REG_DATA:      cfg_data_start = value;
         REG_SPC:       cfg_spc        = value[7:0];
         REG_LIMIT:     cfg_limit      = value[28:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_beats.size() != 0 && !timed_out) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_config(logic [1:0] ft, logic [31:0] fs, logic [31:0] rs,
                              logic [31:0] ds, logic [7:0] spc, logic [28:0] lim);
      drain();
      write_reg(REG_FAT_TYPE, {30'd0, ft});
      write_reg(REG_FAT_START, fs);
      write_reg(REG_ROOT, rs);
      write_reg(REG_DATA, ds);
      write_reg(REG_SPC, {24'd0, spc});
      write_reg(REG_LIMIT, {3'd0, lim});
      csr_write <= 1'b0;
   endtask

   // Pick a link value: mostly valid, sometimes end markers or junk.
   function automatic logic [31:0] pick_link();
      logic [31:0] lim;
      lim = {3'd0, cfg_limit};
      if ($urandom_range(9, 0) < 7 && lim > 2)
         return $urandom_range(lim - 1, 2) | ($urandom() & 32'hF000_0000);
      return $urandom();
   endfunction

   // Reply to the last request, encoding a link the way the table type lays it out.
   task automatic send_reply();
      logic [31:0] v, word;
      logic        failed;
      failed = ($urandom_range(19, 0) == 0);
      v = pick_link();
      word = $urandom();
      if (walk_phase == WP_WORD && cfg_fat_type == FAT12) begin
         if (walk_cluster[0]) word[15:4] = v[11:0];
         else word[11:0] = v[11:0];
      end else if (walk_phase == WP_WORD) begin
         word = (cfg_fat_type == FAT16) ? {word[31:16], v[15:0]} : v;
      end
      send_beat(ACT_REPLY, 0, 0, word, failed);
   endtask

   // A file session: open, then walk or seek, mostly answering a pending table request.
   task automatic run_session(int steps);
      logic [27:0] start;
      int          r;
      r = $urandom_range(9, 0);
      if (r == 0) start = 28'd1;
      else if (r == 1) start = 28'($urandom());
      else if (cfg_limit > 2) start = 28'($urandom_range(cfg_limit - 1, 2));
      else start = 28'($urandom_range(3, 0));
      send_beat(ACT_OPEN, start, $urandom(), $urandom(), 1'($urandom()));
      for (int i = 0; i < steps; i++) begin
         r = $urandom_range(19, 0);
         if (walk_phase != WP_IDLE && r > 1) send_reply();
         else if (r == 0) send_beat(3'($urandom_range(7, 0)), 28'($urandom()), $urandom(),
                                    $urandom(), 1'($urandom()));
         else if (r < 4) send_beat(ACT_SEEK, 0, ($urandom_range(3, 0) == 0) ?
                                   $urandom() : $urandom_range(600, 0), 0, 0);
         else send_beat(ACT_NEXT, 0, 0, 0, 0);
      end
   endtask

   // Check each result beat against the oldest prediction.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = rsp.kind;
         got.sector = rsp.sector;
         got.byte_offset = rsp.byte_offset;
         got.status = rsp.status;
         got.last = rsp.last;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (got != want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls.
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count == WATCHDOG_LIMIT) timed_out <= 1'b1;
   end

   initial begin
      @(posedge timed_out);
      $display("fat_cluster_chain_sector_walker_core regression: fail");
      $finish;
   end

   task automatic test_directed();
      load_config(FAT12, 32'd100, 32'd50, 32'd60, 8'd4, 29'd4000);
      send_beat(ACT_NEXT, 0, 0, 0, 0);
      send_beat(ACT_SEEK, 0, 5, 0, 0);
      send_beat(ACT_REPLY, 0, 0, 32'h1234, 0);
      send_beat(3'd7, 28'hFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // Straddling entry: cluster 341 sits at byte offset 511.
      send_beat(ACT_OPEN, 28'd341, 0, 0, 0);
      repeat (4) send_beat(ACT_NEXT, 0, 0, 0, 0);
      send_beat(ACT_NEXT, 0, 0, 0, 0);
      send_beat(ACT_REPLY, 0, 0, 32'hFFFF_FFAB, 0);
      send_beat(ACT_REPLY, 0, 0, 32'h0000_00CD, 0);
      send_beat(ACT_NEXT, 0, 0, 0, 0);
      // Root area walked to its end, then a seek past it.
      send_beat(ACT_OPEN, 28'd1, 0, 0, 0);
      repeat (11) send_beat(ACT_NEXT, 0, 0, 0, 0);
      send_beat(ACT_SEEK, 0, 32'd10, 0, 0);
      send_beat(ACT_SEEK, 0, 32'hFFFF_FFFF, 0, 0);
      // Seek chain with a failed read, then an out-of-range start cluster.
      send_beat(ACT_OPEN, 28'd2, 0, 0, 0);
      send_beat(ACT_SEEK, 0, 32'd9, 0, 0);
      send_beat(ACT_REPLY, 0, 0, 32'h0000_0003, 0);
      send_beat(ACT_REPLY, 0, 0, 0, 1'b1);
      send_beat(ACT_OPEN, 28'hFFF_FFFF, 0, 0, 0);
      send_beat(ACT_NEXT, 0, 0, 0, 0);
      send_beat(ACT_CLOSE, 0, 0, 0, 0);
   endtask

   task automatic test_random(int items);
      int r;
      int sent;
      sent = 0;
      while (sent < items) begin
         // Each phase uses a fresh geometry, extremes included.
         r = $urandom_range(7, 0);
         case (r)
            0: load_config(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           8'd0, 29'h1FFF_FFFF);
            1: load_config(2'd2, $urandom(), $urandom(), $urandom(), 8'd128,
                           29'd268435457);
            2: load_config(FAT12, 0, 0, 0, 8'd1, 29'd0);
            default: load_config(2'($urandom_range(2, 0)), $urandom(),
                                 $urandom_range(400, 0), $urandom_range(500, 0),
                                 8'($urandom_range(8, 1)),
                                 29'(($urandom_range(3, 0) == 0) ? $urandom() :
                                     $urandom_range(5000, 2)));
         endcase
         r = $urandom_range(30, 5);
         run_session(r);
         sent += r + 1;
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = REG_FAT_TYPE;
      csr_data        = '0;
      req.valid       = 1'b0;
      req.action      = ACT_OPEN;
      req.open_cluster  = '0;
      req.sector_index  = '0;
      req.fat_data      = '0;
      req.read_failed   = 1'b0;
      rsp.ready       = 1'b0;
      error_count     = 0;
      idle_count      = 0;
      timed_out       = 1'b0;
      send_gap_pct    = 13;
      recv_stall_pct  = 67;
      cfg_fat_type = FAT16; cfg_fat_start = 0; cfg_root_start = 0;
      cfg_data_start = 0; cfg_spc = 8'd1; cfg_limit = 0;
      walk_first = 0; walk_cluster = 0; walk_sector = 0; walk_phase = WP_IDLE;
      walk_seek = 0; walk_hops = 0; walk_high = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(380);
      send_gap_pct   = 67;
      recv_stall_pct = 13;
      test_random(380);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      test_random(400);
      drain();

      if (error_count == 0)
         $display("fat_cluster_chain_sector_walker_core regression: pass");
      else
         $display("fat_cluster_chain_sector_walker_core regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
